/* design/bcbsc_pkg.sv */
// Package: shared types, register indexes and key byte tables for the chained byte cipher.
`timescale 1ns / 1ps

package bcbsc_pkg;

   localparam int KeyWidth    = 64;
   localparam int LengthWidth = 31;
   localparam int IndexWidth  = 7;

   // Configuration register indexes
   localparam logic [1:0] CSR_CIPHER_KEY     = 2'd0;
   localparam logic [1:0] CSR_CIPHER_TYPE    = 2'd1;
   localparam logic [1:0] CSR_ENCRYPT_MODE   = 2'd2;
   localparam logic [1:0] CSR_MESSAGE_LENGTH = 2'd3;

   // Block sizes in bytes
   localparam logic [7:0] BLOCK_SIZE_SHORT = 8'h40;
   localparam logic [7:0] BLOCK_SIZE_LONG  = 8'h80;

   typedef logic [5:0] shift_type;

   // Bit offsets of the key byte, by byte position (type 0)
   localparam shift_type SHIFT_BY_POS [8] = '{
      6'h00, 6'h28, 6'h18, 6'h08, 6'h20, 6'h38, 6'h10, 6'h30
   };

   // Bit offsets of the key byte, by running key low bits (type 1)
   localparam shift_type SHIFT_BY_KEY [8] = '{
      6'h38, 6'h20, 6'h30, 6'h10, 6'h28, 6'h00, 6'h08, 6'h18
   };

   typedef struct packed {
      logic [KeyWidth-1:0]    cipher_key;
      logic                   cipher_type;
      logic                   encrypt_mode;
      logic [LengthWidth-1:0] message_length;
   } cfg_type;

endpackage

/* design/bcbsc_csr.sv */
// Configuration register file for the chained byte cipher.
`timescale 1ns / 1ps

module bcbsc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_write_data,
   output bcbsc_pkg::cfg_type     cfg
);
   import bcbsc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CIPHER_KEY:     cfg_ff.cipher_key     <= csr_write_data;
            CSR_CIPHER_TYPE:    cfg_ff.cipher_type    <= csr_write_data[0];
            CSR_ENCRYPT_MODE:   cfg_ff.encrypt_mode   <= csr_write_data[0];
            CSR_MESSAGE_LENGTH: cfg_ff.message_length <= csr_write_data[LengthWidth-1:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/bcbsc_core.sv */
// Cipher state and per-byte step: key chaining, key byte select, XOR and bit gathering.
`timescale 1ns / 1ps

module bcbsc_core (
   input  logic                clock,
   input  logic                reset,
   input  bcbsc_pkg::cfg_type  cfg,
   input  logic                step_en,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output logic [7:0]          out_byte
);
   import bcbsc_pkg::*;

   logic [KeyWidth-1:0]   key_ff, key_in;
   logic [KeyWidth-1:0]   gath_ff, gath_in;
   logic [2:0]            pos_ff, pos_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic [2:0]            blk_ff, blk_in;
   logic                  head_ff, head_in;
   logic                  start_ff;
   logic                  type_ff, type_in;
   logic                  enc_ff, enc_in;
   logic [IndexWidth-1:0] head_len_ff, head_len_in;

   logic [KeyWidth-1:0]   key0, key1, gath0, gath1, gath_bit;
   logic [2:0]            pos0, blk0;
   logic [IndexWidth-1:0] idx0;
   logic                  head0, blk_start;
   shift_type             sh;
   logic [7:0]            result, gsrc, gmask;
   logic [7:0]            idx_inc, blk_size;

   always_comb begin
      // message start takes fresh configuration and clean state
      type_in     = start_ff ? cfg.cipher_type  : type_ff;
      enc_in      = start_ff ? cfg.encrypt_mode : enc_ff;
      head_len_in = start_ff
                  ? (cfg.cipher_type ? cfg.message_length[6:0]
                                     : {1'b0, cfg.message_length[5:0]})
                  : head_len_ff;
      key0  = start_ff ? cfg.cipher_key : key_ff;
      gath0 = start_ff ? '0 : gath_ff;
      pos0  = start_ff ? '0 : pos_ff;
      idx0  = start_ff ? '0 : idx_ff;
      blk0  = start_ff ? '0 : blk_ff;
      head0 = start_ff ? (head_len_in != '0) : head_ff;

      // chain gathered bits into the key at each block start
      blk_start = !head0 && (idx0 == '0);
      key1   = blk_start ? (key0 ^ gath0) : key0;
      gath1  = blk_start ? '0 : gath0;
      blk_in = blk_start ? 3'(blk0 + 3'd1) : blk0;

      sh     = type_in ? SHIFT_BY_KEY[key1[2:0]] : SHIFT_BY_POS[pos0];
      result = key1[sh +: 8] ^ data_byte;

      gsrc     = enc_in ? result : data_byte;
      gmask    = head0 ? 8'h01 : (8'h01 << blk_in);
      gath_bit = {56'b0, gsrc & gmask} << idx0[5:0];
      gath_in  = gath1 | gath_bit;
      key_in   = key1;
      pos_in   = 3'(pos0 + 3'd1);

      idx_inc  = {1'b0, idx0} + 8'd1;
      blk_size = type_in ? BLOCK_SIZE_LONG : BLOCK_SIZE_SHORT;
      head_in  = head0;
      idx_in   = idx_inc[IndexWidth-1:0];
      if (head0) begin
         if (idx_inc >= {1'b0, head_len_in}) begin
            head_in = 1'b0;
            idx_in  = '0;
         end
      end else if (idx_inc >= blk_size) begin
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= 1'b1;
         key_ff      <= '0;
         gath_ff     <= '0;
         pos_ff      <= '0;
         idx_ff      <= '0;
         blk_ff      <= '0;
         head_ff     <= 1'b0;
         type_ff     <= 1'b0;
         enc_ff      <= 1'b0;
         head_len_ff <= '0;
      end else if (step_en) begin
         start_ff    <= last_byte;
         key_ff      <= key_in;
         gath_ff     <= gath_in;
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         blk_ff      <= blk_in;
         head_ff     <= head_in;
         type_ff     <= type_in;
         enc_ff      <= enc_in;
         head_len_ff <= head_len_in;
      end
   end

   assign out_byte = result;

endmodule

/* design/block_chained_byte_stream_cipher.sv */
// Top level of the chained byte stream cipher: request/response pipeline around the core.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one message byte and a last
//   marker; the response channel (rsp_valid/rsp_ready) returns the enciphered
//   or deciphered byte with the marker copied. One response per request, in order.
//   Configuration is written through csr_write_en/csr_index/csr_write_data while
//   idle; key, type, mode and length are sampled at the first byte of a message.
//   A taken request enters the request register; the core step then writes its
//   result into the response register, from which the response is offered.
//   Throughput: one byte per cycle unless the response stalls; the key and gather
//   update is a combinational step between the request and response registers.
//   Reset (synchronous, active high) empties both registers, clears the
//   configuration and arms message start.
//   When the receiver stalls, the response holds; the request register still
//   takes one more byte, then req_ready drops until the response is taken.
`timescale 1ns / 1ps

module block_chained_byte_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import bcbsc_pkg::*;

   cfg_type    cfg;
   logic       s1_valid_ff, s1_last_ff;
   logic [7:0] s1_data_ff;
   logic       rsp_valid_ff, rsp_last_ff;
   logic [7:0] rsp_byte_ff;
   logic       advance;
   logic [7:0] core_byte;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   bcbsc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   bcbsc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (advance),
      .data_byte (s1_data_ff),
      .last_byte (s1_last_ff),
      .out_byte  (core_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (advance) begin
         rsp_byte_ff <= core_byte;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

/* design/bcbsc_checker.sv */
// Port-level assertions for the chained byte cipher, bound to the top level.
`timescale 1ns / 1ps

module bcbsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("stalled response changed");

   // backpressure only when both stages are full and the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without a stalled response");

   // a new response comes from an earlier taken request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

endmodule

bind block_chained_byte_stream_cipher bcbsc_checker u_bcbsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

/* dv/byte_cipher_checker.sv */
// Checker: watches the request, response and register ports, predicts each cipher byte and compares.
`timescale 1ns / 1ps

module byte_cipher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_out_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          fail_count,
   output int          outstanding
);
   import bcbsc_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_rsp_type;

   // key byte offsets: by byte position (short blocks) and by key low bits (long blocks)
   localparam logic [5:0] POS_SHIFT [8] = '{6'd0, 6'd40, 6'd24, 6'd8, 6'd32, 6'd56, 6'd16, 6'd48};
   localparam logic [5:0] KEY_SHIFT [8] = '{6'd56, 6'd32, 6'd48, 6'd16, 6'd40, 6'd0, 6'd8, 6'd24};

   cfg_type        cfg;
   logic [63:0]    run_key;
   logic [63:0]    gathered;
   logic [2:0]     byte_pos;
   logic [2:0]     block_num;
   int unsigned    run_idx;
   int unsigned    head_len;
   logic           in_head;
   logic           msg_start;
   logic           msg_long;
   logic           msg_encrypt;
   cipher_rsp_type pending_cipher_bytes [$];

   function automatic cipher_rsp_type cipher_next_byte(input logic [7:0] data, input logic last);
      cipher_rsp_type rsp;
      int unsigned    blk_size;
      logic [5:0]     shift;
      logic [7:0]     result;
      logic [7:0]     gated;
      if (msg_start) begin
         msg_long    = cfg.cipher_type;
         msg_encrypt = cfg.encrypt_mode;
         blk_size    = msg_long ? int'(BLOCK_SIZE_LONG) : int'(BLOCK_SIZE_SHORT);
         head_len    = cfg.message_length % blk_size;
         run_key     = cfg.cipher_key;
         gathered    = '0;
         byte_pos    = '0;
         run_idx     = 0;
         block_num   = '0;
         in_head     = (head_len != 0);
         msg_start   = 1'b0;
      end
      blk_size = msg_long ? int'(BLOCK_SIZE_LONG) : int'(BLOCK_SIZE_SHORT);

      // chain the previous part into the key at each block start
      if (!in_head && run_idx == 0) begin
         run_key   = run_key ^ gathered;
         gathered  = '0;
         block_num = block_num + 3'd1;
      end

      shift  = msg_long ? KEY_SHIFT[run_key[2:0]] : POS_SHIFT[byte_pos];
      result = 8'(run_key >> shift) ^ data;
      gated  = msg_encrypt ? result : data;
      if (in_head)
         gathered = gathered | ({63'd0, gated[0]} << (run_idx & 63));
      else
         gathered = gathered | ({56'd0, gated & (8'd1 << block_num)} << (run_idx & 63));

      byte_pos = byte_pos + 3'd1;
      run_idx  = run_idx + 1;
      if (in_head) begin
         if (run_idx >= head_len) begin
            in_head = 1'b0;
            run_idx = 0;
         end
      end else if (run_idx >= blk_size) begin
         run_idx = 0;
      end
      run_idx = run_idx & 127;
      if (last)
         msg_start = 1'b1;

      rsp.out_byte = result;
      rsp.out_last = last;
      return rsp;
   endfunction

   always @(posedge clock) begin : watch
      cipher_rsp_type want;
      if (reset) begin
         fail_count = 0;
         cfg       = '0;
         run_key   = '0;
         gathered  = '0;
         byte_pos  = '0;
         block_num = '0;
         run_idx   = 0;
         head_len  = 0;
         in_head   = 1'b0;
         msg_start = 1'b1;
         msg_long  = 1'b0;
         msg_encrypt = 1'b0;
         pending_cipher_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_cipher_bytes.size() == 0) begin
               $error("unexpected response: out_byte %h out_last %b", rsp_out_byte, rsp_out_last);
               fail_count++;
            end else begin
               want = pending_cipher_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_last !== want.out_last) begin
                  $error("out_last expected %b actual %b", want.out_last, rsp_out_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_cipher_bytes.push_back(cipher_next_byte(req_data_byte, req_last_byte));
         if (csr_write_en) begin
            case (csr_index)
               CSR_CIPHER_KEY: begin
                  cfg.cipher_key = csr_write_data;
               end
               CSR_CIPHER_TYPE: begin
                  cfg.cipher_type = csr_write_data[0];
               end
               CSR_ENCRYPT_MODE: begin
                  cfg.encrypt_mode = csr_write_data[0];
               end
               CSR_MESSAGE_LENGTH: begin
                  cfg.message_length = csr_write_data[LengthWidth-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      outstanding = pending_cipher_bytes.size();
   end

endmodule

/* dv/tb_block_chained_byte_stream_cipher.sv */
// Testbench top: clock, reset, request and register stimulus, response stalls and the verdict.
`timescale 1ns / 1ps

module tb_block_chained_byte_stream_cipher;
   import bcbsc_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;
   int          fail_count;
   int          outstanding;
   int          rsp_taken = 0;
   bit          sender_idle_on;

   block_chained_byte_stream_cipher u_dut (.*);

   byte_cipher_checker u_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         rsp_taken <= rsp_taken + 1;

   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int draw_gap();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   task automatic send_request(input logic [7:0] data, input logic last);
      int gap;
      gap = sender_idle_on ? draw_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
   endtask

   // upper data bits of the narrow registers carry junk
   task automatic load_config(input logic [63:0] key, input logic long_blocks,
                              input logic encrypt, input logic [30:0] length);
      drain();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_CIPHER_KEY;
      csr_write_data <= key;
      @(negedge clock);
      csr_index      <= CSR_CIPHER_TYPE;
      csr_write_data <= {31'($urandom), 32'($urandom), long_blocks};
      @(negedge clock);
      csr_index      <= CSR_ENCRYPT_MODE;
      csr_write_data <= {31'($urandom), 32'($urandom), encrypt};
      @(negedge clock);
      csr_index      <= CSR_MESSAGE_LENGTH;
      csr_write_data <= {1'($urandom), 32'($urandom), length};
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin : response_side
      int span;
      bit held_off;
      bit stalls_on;
      rsp_ready = 1'b0;
      held_off  = 1'b0;
      stalls_on = 1'b1;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held_off && rsp_taken >= 150) begin
            held_off = 1'b1;
            span = 400;
            rsp_ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            span = 1 + draw_gap();
            rsp_ready <= 1'b0;
         end else begin
            span = $urandom_range(1, 8);
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 31) == 0)
            stalls_on = !stalls_on;
         repeat (span - 1) @(negedge clock);
      end
   end

   initial begin : stimulus
      int          sent;
      int          count;
      int          pick;
      logic [30:0] len;
      logic [63:0] key;
      bit          ends;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_last_byte  = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_CIPHER_KEY;
      csr_write_data = '0;
      sender_idle_on = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: zero key, short blocks, no head
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b1);
      // all-ones key, long blocks, longest head, early last
      load_config('1, 1'b1, 1'b1, 31'h7fffffff);
      send_request(8'hff, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'ha5, 1'b1);
      // short head then bytes past the length
      load_config(64'h0123456789abcdef, 1'b0, 1'b0, 31'd3);
      for (int i = 0; i < 5; i++)
         send_request(8'h3c ^ 8'(i * 37), i == 4);
      // register writes in the middle of a message are ignored until the next one
      load_config(64'hfedcba9876543210, 1'b1, 1'b0, 31'd2);
      send_request(8'h81, 1'b0);
      send_request(8'h7e, 1'b0);
      load_config(64'h8000000000000001, 1'b0, 1'b1, 31'd0);
      send_request(8'h55, 1'b0);
      send_request(8'haa, 1'b1);

      sent = 0;
      while (sent < 600) begin
         pick = $urandom_range(0, 7);
         if (pick == 0)
            key = '0;
         else if (pick == 1)
            key = '1;
         else
            key = {$urandom, $urandom};
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            len   = 31'($urandom_range(520, 640));
            count = len;
         end else if (pick == 1) begin
            len   = $urandom_range(0, 1) ? 31'h7fffffff : 31'($urandom);
            count = $urandom_range(1, 150);
         end else begin
            len   = 31'($urandom_range(0, 200));
            count = len;
         end
         if (pick != 1) begin
            case ($urandom_range(0, 7))
               0: count = (len > 1) ? $urandom_range(1, len) : 1;
               1: count = len + $urandom_range(1, 70);
               default: begin
               end
            endcase
            if (count == 0)
               count = $urandom_range(1, 70);
         end
         ends = ($urandom_range(0, 7) != 0);
         load_config(key, 1'($urandom), 1'($urandom), len);
         sender_idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < count; i++)
            send_request(8'($urandom_range(0, 255)), ends && (i == count - 1));
         sent += count;
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
